// ----- rtl/dswd_pkg.sv -----
// Shared constants, status codes and types for the distinct symbol window detector.
package dswd_pkg;

  localparam int unsigned ALPHABET   = 26;
  localparam int unsigned MAX_STRING = 65535;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned RUN_W    = 5;
  localparam int unsigned WIN_W    = 5;
  localparam int unsigned STAT_W   = 3;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

  typedef enum logic [STAT_W-1:0] {
    ST_SEARCH   = 3'd0,
    ST_FOUND    = 3'd1,
    ST_ENDED    = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // One write into the position table; also the shape of the bypass register.
  typedef struct packed {
    logic                en;
    logic [LETTER_W-1:0] addr;
    logic [POS_W-1:0]    data;
  } pos_wr_t;

endpackage

// ----- rtl/dswd_pos_ram.sv -----
// Last-seen position table: one write port, one read port, registered read data.
module dswd_pos_ram (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [dswd_pkg::LETTER_W-1:0]  rd_addr_i,
  output logic [dswd_pkg::POS_W-1:0]     rd_data_o,
  input  dswd_pkg::pos_wr_t              wr_i
);
  import dswd_pkg::*;

  logic [POS_W-1:0] mem_q [ALPHABET];
  logic [POS_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/distinct_symbol_window_detector_unit.sv -----
// Top level of the distinct symbol window detector.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) moves one symbol beat: a letter
//   index, a string start flag and a string end flag. Output channel
//   (out_valid_o / out_ready_i) moves exactly one status beat per symbol,
//   in order, with the 1-based marker position when the status is found.
//   Config channel (cfg_valid_i / cfg_ready_o) writes window_length; it is
//   always ready and is meant to be written while the block is idle.
// Pipeline and throughput:
//   The accepting edge issues the table read and loads the compute stage,
//   which loads the output register when it commits. One symbol per cycle
//   is sustained unless the output stalls: the read-modify-write of run
//   length, position and last-seen entry closes when the compute stage
//   commits, and a bypass register covers a back-to-back same-letter repeat.
// Reset:
//   Clears the valid bits, run length, position, marker flag and pipeline
//   valids, and loads window_length with 4. Table contents need no clear.
// Stall:
//   A held output beat keeps the compute stage full; the input then stalls
//   once that stage is full too. No beat is lost or repeated.
module distinct_symbol_window_detector_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dswd_pkg::WIN_W-1:0]     cfg_window_length_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dswd_pkg::LETTER_W-1:0]  letter_index_i,
  input  logic                           string_start_i,
  input  logic                           string_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dswd_pkg::STAT_W-1:0]    status_o,
  output logic [dswd_pkg::POS_W-1:0]     marker_position_o
);
  import dswd_pkg::*;

  // Configuration register.
  logic [WIN_W-1:0] window_q;

  // Compute stage holding the symbol whose table read is in flight.
  logic                s1_valid_q;
  logic [LETTER_W-1:0] s1_letter_q;
  logic                s1_start_q;
  logic                s1_end_q;

  // String state.
  logic [RUN_W-1:0] run_q, run_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             done_q, done_d;
  logic             seen_q [ALPHABET];

  // Output register.
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [POS_W-1:0] mpos_q, mpos_d;

  // Table access.
  logic             in_accept;
  logic             commit;
  logic             rd_en;
  logic [POS_W-1:0] rd_data;
  pos_wr_t          wr;
  pos_wr_t          fwd_q;

  // Compute stage working values.
  logic             s1_in_range;
  logic             hit_valid;
  logic [RUN_W-1:0] run_cur;
  logic [RUN_W-1:0] run_inc;
  logic [POS_W-1:0] pos_cur;
  logic             done_cur;
  logic [POS_W-1:0] last_pos;
  logic [POS_W-1:0] gap;

  assign cfg_ready_o = 1'b1;

  // Advance the compute stage when the output register is free or draining.
  assign commit     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || commit;
  assign in_accept  = in_valid_i && in_ready_o;

  // Skip the read for letters outside the alphabet; their data is never used.
  assign rd_en = in_accept && (letter_index_i < LETTER_W'(ALPHABET));

  dswd_pos_ram u_pos_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (letter_index_i),
    .rd_data_o (rd_data),
    .wr_i      (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_window_length_i;
    end
  end

  // Capture the symbol together with the write that lands on the same edge
  // as its read, so a same-letter repeat sees the fresh position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= '0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      fwd_q      <= wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_letter_q <= letter_index_i;
      s1_start_q  <= string_start_i;
      s1_end_q    <= string_end_i;
    end
  end

  // Read-modify-write of the string state for the symbol in the compute stage.
  always_comb begin
    s1_in_range = s1_letter_q < LETTER_W'(ALPHABET);
    run_cur     = s1_start_q ? '0 : run_q;
    pos_cur     = s1_start_q ? '0 : pos_q;
    done_cur    = s1_start_q ? 1'b0 : done_q;
    hit_valid   = 1'b0;
    if (s1_in_range && !s1_start_q) begin
      hit_valid = seen_q[s1_letter_q];
    end
    last_pos = (fwd_q.en && (fwd_q.addr == s1_letter_q)) ? fwd_q.data : rd_data;
    gap      = pos_cur - last_pos;
    run_inc  = run_cur + RUN_W'(1);

    run_d    = run_cur;
    pos_d    = pos_cur;
    done_d   = done_cur;
    status_d = ST_SEARCH;
    mpos_d   = '0;
    wr.en    = 1'b0;
    wr.addr  = s1_letter_q;
    wr.data  = pos_cur;

    priority if (done_cur) begin
      status_d = ST_IGNORED;
    end else if (pos_cur >= POS_W'(MAX_STRING)) begin
      status_d = ST_OVERFLOW;
    end else begin
      pos_d    = pos_cur + POS_W'(1);
      status_d = s1_end_q ? ST_ENDED : ST_SEARCH;
      if (!s1_in_range) begin
        run_d = '0;
      end else begin
        wr.en = commit;
        if (hit_valid && (gap <= POS_W'(run_cur))) begin
          run_d = gap[RUN_W-1:0];
        end else begin
          run_d = run_inc;
          if (run_inc == window_q) begin
            done_d   = 1'b1;
            status_d = ST_FOUND;
            mpos_d   = pos_cur + POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      pos_q  <= '0;
      done_q <= 1'b0;
      for (int k = 0; k < ALPHABET; k++) begin
        seen_q[k] <= 1'b0;
      end
    end else if (commit) begin
      run_q  <= run_d;
      pos_q  <= pos_d;
      done_q <= done_d;
      for (int k = 0; k < ALPHABET; k++) begin
        if (wr.en && (wr.addr == LETTER_W'(k))) begin
          seen_q[k] <= 1'b1;
        end else if (s1_start_q) begin
          seen_q[k] <= 1'b0;
        end
      end
    end
  end

  // Output register: load on commit, drop the beat once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      mpos_q   <= mpos_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign marker_position_o = mpos_q;

endmodule

// ----- tb/tb_distinct_symbol_window_detector_unit.sv -----
// Testbench for the distinct symbol window detector: directed and random strings, a checker and a watchdog.
`timescale 1ns / 1ps

module tb_distinct_symbol_window_detector_unit;
  import dswd_pkg::*;

  // Cycles without any accepted beat before the run is called hung.
  localparam int unsigned QUIET_LIMIT   = 2000;
  // Length of the forced receiver hold-off used to fill the block up.
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned PHASE_SYMBOLS = 100;
  localparam int unsigned PHASE_COUNT   = 12;

  typedef enum int {
    PACE_FULL,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_e;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
  } status_beat_t;

  // Tracks the per-string letter table and run length, and holds the status
  // beats still owed by the block in acceptance order.
  class marker_scoreboard;
    int unsigned        seen_pos[ALPHABET];
    bit                 seen_valid[ALPHABET];
    int unsigned        run_len;
    int unsigned        sym_pos;
    bit                 marker_done;
    logic [WIN_W-1:0]   window;
    status_beat_t       status_due_q[$];
    int unsigned        errors;

    function new();
      window = WINDOW_RESET;
      errors = 0;
      foreach (seen_pos[i]) seen_pos[i] = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (seen_valid[i]) seen_valid[i] = 1'b0;
      run_len     = 0;
      sym_pos     = 0;
      marker_done = 1'b0;
    endfunction

    function void set_window(logic [WIN_W-1:0] value);
      window = value;
    endfunction

    function int unsigned pending_count();
      return status_due_q.size();
    endfunction

    // Advance the string state by one accepted symbol and queue its status.
    function void note_symbol(logic [LETTER_W-1:0] letter, logic start, logic last);
      status_beat_t beat;
      int unsigned  gap;
      bit           found;
      found         = 1'b0;
      beat.position = '0;
      if (start) clear_string();
      if (marker_done) begin
        beat.status = ST_IGNORED;
      end else if (sym_pos >= MAX_STRING) begin
        beat.status = ST_OVERFLOW;
      end else begin
        if (letter >= ALPHABET) begin
          // Out-of-range symbol: takes a position, breaks the run, not stored.
          run_len = 0;
        end else begin
          gap = sym_pos - seen_pos[letter];
          if (seen_valid[letter] && gap <= run_len) begin
            // Repeat inside the run: shrink to the distance since last sighting.
            run_len = gap;
          end else begin
            run_len++;
            if (run_len == window) found = 1'b1;
          end
          seen_pos[letter]   = sym_pos;
          seen_valid[letter] = 1'b1;
        end
        sym_pos++;
        if (found) begin
          marker_done   = 1'b1;
          beat.status   = ST_FOUND;
          beat.position = POS_W'(sym_pos);
        end else begin
          beat.status = last ? ST_ENDED : ST_SEARCH;
        end
      end
      status_due_q.push_back(beat);
    endfunction

    // Compare one delivered status beat against the oldest one owed.
    function void check_status(logic [STAT_W-1:0] status, logic [POS_W-1:0] position);
      status_beat_t want;
      bit           bad;
      bad = 1'b0;
      if (status_due_q.size() == 0) begin
        errors++;
        $display("%0t: status beat expected none, got status %0d position %0d",
                 $time, status, position);
        return;
      end
      want = status_due_q.pop_front();
      if (status !== want.status) begin
        bad = 1'b1;
        $display("%0t: status expected %0d got %0d", $time, want.status, status);
      end
      if (position !== want.position) begin
        bad = 1'b1;
        $display("%0t: marker_position expected %0d got %0d",
                 $time, want.position, position);
      end
      if (bad) errors++;
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [WIN_W-1:0]    cfg_window_length_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [LETTER_W-1:0] letter_index_i;
  logic                string_start_i;
  logic                string_end_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STAT_W-1:0]   status_o;
  logic [POS_W-1:0]    marker_position_o;

  marker_scoreboard sb;

  // Pacing knobs, set per phase by the stimulus process.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  int unsigned quiet_cycles;

  distinct_symbol_window_detector_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_window_length_i (cfg_window_length_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .letter_index_i      (letter_index_i),
    .string_start_i      (string_start_i),
    .string_end_i        (string_end_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .marker_position_o   (marker_position_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sample every channel at the edge, in one process, so that a symbol is
  // always noted before any status beat of the same edge is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_window(cfg_window_length_i);
      if (in_valid_i && in_ready_o) sb.note_symbol(letter_index_i, string_start_i, string_end_i);
      if (out_valid_o && out_ready_i) sb.check_status(status_o, marker_position_o);
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: watchdog expired, no beat accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stalls per the current pace, plus a long hold-off on
  // request so the block fills up and pushes back on its input.
  initial begin
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FULL: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND_GAPS: begin
        send_gap_pct   = 68;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALLS: begin
        send_gap_pct   = 0;
        recv_stall_pct = 68;
      end
      default: begin
        send_gap_pct   = 31;
        recv_stall_pct = 31;
      end
    endcase
  endtask

  // Offer one symbol beat, with an optional random gap first; hold it
  // until the block takes it.
  task automatic send_symbol(input logic [LETTER_W-1:0] letter, input bit start, input bit last);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    letter_index_i <= letter;
    string_start_i <= start;
    string_end_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every owed status beat has been delivered.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_count() != 0);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] value);
    cfg_valid_i         <= 1'b1;
    cfg_window_length_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly letters from a random span of the alphabet, so repeats can be common; rarely a code
  // past the alphabet.
  function automatic logic [LETTER_W-1:0] pick_letter(int unsigned span, int unsigned base);
    if ($urandom_range(0, 29) == 0) return LETTER_W'($urandom_range(ALPHABET, 31));
    return LETTER_W'(base + $urandom_range(0, span - 1));
  endfunction

  // One string: a random prefix, usually a run of distinct letters sized to
  // the window when it fits the alphabet (sometimes one short), then a random tail.
  // Start and end flags are mostly well formed, with some missing or stray.
  task automatic send_random_string(input int unsigned win, inout int unsigned sent);
    logic [LETTER_W-1:0] letters[$];
    logic [LETTER_W-1:0] deck[ALPHABET];
    logic [LETTER_W-1:0] swap;
    int unsigned         span;
    int unsigned         base;
    int unsigned         seg;
    int unsigned         j;
    bit                  start_flag;
    bit                  end_flag;
    span = $urandom_range(1, ALPHABET);
    base = $urandom_range(0, ALPHABET - span);
    repeat ($urandom_range(0, 12)) letters.push_back(pick_letter(span, base));
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < ALPHABET; i++) deck[i] = LETTER_W'(i);
      for (int i = ALPHABET - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        swap    = deck[i];
        deck[i] = deck[j];
        deck[j] = swap;
      end
      seg = (win >= 1 && win <= ALPHABET) ? win : $urandom_range(20, ALPHABET);
      if (seg > 1 && $urandom_range(0, 3) == 0) seg--;
      for (int i = 0; i < seg; i++) letters.push_back(deck[i]);
    end
    repeat ($urandom_range(0, 6)) letters.push_back(pick_letter(span, base));
    if (letters.size() == 0) letters.push_back(pick_letter(span, base));
    foreach (letters[i]) begin
      start_flag = (i == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 39) == 0);
      end_flag   = (i == letters.size() - 1) ? ($urandom_range(0, 7) != 0)
                                             : ($urandom_range(0, 19) == 0);
      send_symbol(letters[i], start_flag, end_flag);
      sent++;
    end
  endtask

  initial begin
    int unsigned win;
    int unsigned sent;
    bit          held;
    bit          paused;
    sb                  = new();
    rst_ni              = 1'b0;
    cfg_valid_i         = 1'b0;
    cfg_window_length_i = '0;
    in_valid_i          = 1'b0;
    letter_index_i      = '0;
    string_start_i      = 1'b0;
    string_end_i        = 1'b0;
    hold_request        = 1'b0;
    set_pace(PACE_FULL);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed symbols at the reset window of four.
    // Plain marker on the fourth symbol, then a symbol ignored after it.
    send_symbol(LETTER_W'(0), 1'b1, 1'b0);
    send_symbol(LETTER_W'(1), 1'b0, 1'b0);
    send_symbol(LETTER_W'(2), 1'b0, 1'b0);
    send_symbol(LETTER_W'(3), 1'b0, 1'b0);
    send_symbol(LETTER_W'(4), 1'b0, 1'b1);
    // Top letter, a repeat inside the run, then the marker two symbols later.
    send_symbol(LETTER_W'(25), 1'b1, 1'b0);
    send_symbol(LETTER_W'(24), 1'b0, 1'b0);
    send_symbol(LETTER_W'(25), 1'b0, 1'b0);
    send_symbol(LETTER_W'(23), 1'b0, 1'b0);
    send_symbol(LETTER_W'(22), 1'b0, 1'b0);
    // Codes past the alphabet break the run; string ends with no marker.
    send_symbol(LETTER_W'(31), 1'b1, 1'b0);
    send_symbol(LETTER_W'(ALPHABET), 1'b0, 1'b0);
    send_symbol(LETTER_W'(0), 1'b0, 1'b0);
    send_symbol(LETTER_W'(0), 1'b0, 1'b1);
    // No start after the end flag: the same string carries on to a marker.
    send_symbol(LETTER_W'(1), 1'b0, 1'b0);
    send_symbol(LETTER_W'(2), 1'b0, 1'b0);
    send_symbol(LETTER_W'(3), 1'b0, 1'b0);
    // A letter seen earlier but outside the run counts as new; the marker
    // lands on a symbol that also carries the end flag.
    send_symbol(LETTER_W'(0), 1'b1, 1'b0);
    send_symbol(LETTER_W'(1), 1'b0, 1'b0);
    send_symbol(LETTER_W'(1), 1'b0, 1'b0);
    send_symbol(LETTER_W'(2), 1'b0, 1'b0);
    send_symbol(LETTER_W'(0), 1'b0, 1'b0);
    send_symbol(LETTER_W'(3), 1'b0, 1'b1);
    wait_drained();

    // Random phases: window extremes first (one, full alphabet, zero and
    // values past the alphabet that never match), then two, then random windows.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       win = 1;
        1:       win = ALPHABET;
        2:       win = 0;
        3:       win = 31;
        4:       win = ALPHABET + 1;
        5:       win = 2;
        default: win = $urandom_range(2, ALPHABET - 1);
      endcase
      write_window(WIN_W'(win));
      set_pace(pace_e'(p % 4));
      sent   = 0;
      held   = 1'b0;
      paused = 1'b0;
      while (sent < PHASE_SYMBOLS) begin
        send_random_string(win, sent);
        // Hold the receiver off while the sender keeps pushing.
        if (p == 4 && !held && sent > 30) begin
          hold_request = 1'b1;
          held         = 1'b1;
        end
        // Pause the sender until every owed status has come out.
        if (p == 1 && !paused && sent > 40) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (sb.pending_count() != 0)
      $display("%0t: %0d status beats never delivered", $time, sb.pending_count());
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- distinct_symbol_window_detector_unit.f -----
rtl/dswd_pkg.sv
rtl/dswd_pos_ram.sv
rtl/distinct_symbol_window_detector_unit.sv
tb/tb_distinct_symbol_window_detector_unit.sv
